FILE: rtl/act_pkg.sv
// ----------------------------------------------------------------------------
// act_pkg
// Shared widths, constants and controller/datapath signal groups for the
// active client tracker.
// ----------------------------------------------------------------------------
package act_pkg;

	localparam int KEY_W             = 48;
	localparam int TIME_W            = 32;
	localparam int OUT_W             = 6;
	localparam int DEF_TABLE_ENTRIES = 32;

	localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000000;
	localparam logic [OUT_W-1:0]  OUT_MAX      = 6'd63;

	// controller -> datapath
	typedef struct packed {
		logic start;     // latch the touch, clear scan accumulators
		logic rd_en;     // issue a table read at the scan index
		logic eval;      // read data valid: compare, refresh, count
		logic final_wr;  // store a new key, add the new client
		logic load_out;  // move the count into the result register
	} act_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic used_zero; // table empty, nothing to scan
		logic last_rd;   // scan index is on the last used entry
	} act_sts_t;

endpackage

FILE: rtl/act_if.sv
// ----------------------------------------------------------------------------
// act_if
// Valid/ready channels of the active client tracker: touch, result and
// window configuration.
// ----------------------------------------------------------------------------
interface act_touch_if;
	logic                        valid;
	logic                        ready;
	logic [act_pkg::KEY_W-1:0]   client_key;
	logic [act_pkg::TIME_W-1:0]  now_time;

	modport source (output valid, output client_key, output now_time, input ready);
	modport sink   (input valid, input client_key, input now_time, output ready);
endinterface

interface act_result_if;
	logic                       valid;
	logic                       ready;
	logic [act_pkg::OUT_W-1:0]  active_clients;

	modport source (output valid, output active_clients, input ready);
	modport sink   (input valid, input active_clients, output ready);
endinterface

interface act_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [act_pkg::TIME_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/active_client_tracker.sv
// ----------------------------------------------------------------------------
// active_client_tracker
// Table of recently seen client keys with a per-entry timeout; reports the
// number of clients active within the window for every touch.
// ----------------------------------------------------------------------------
// A touch (client_key, now_time) is taken only while the block is idle. The
// sequencer then reads the used entries from the key and seen-time RAMs one
// per cycle; read data is registered in the RAMs and compared in the next cycle
// against the key and the window in a single datapath stage, so the time one
// touch takes grows with the number of used entries and is bounded by the
// single read port of the tables. A matching entry has
// its seen time rewritten to now; the first expired entry is kept as the
// slot to reuse, and an unknown key goes there or is appended while there
// is room. The new client is counted even when nothing could be stored. The
// result goes into an output register, so a new touch is accepted while the
// previous count still waits to be taken. The window register (cfg, reset
// 1000000 ticks) is always ready and should be written only when idle. No
// clearing pass is needed after reset: only entries below the fill count
// are ever read.
// ----------------------------------------------------------------------------
module active_client_tracker #(
	parameter int TABLE_ENTRIES = act_pkg::DEF_TABLE_ENTRIES
) (
	input logic          clk,
	input logic          arst_n,
	act_touch_if.sink    touch,
	act_result_if.source result,
	act_cfg_if.sink      cfg
);
	import act_pkg::*;

	act_cmd_t cmd;
	act_sts_t sts;

	// window register takes every beat
	assign cfg.ready = 1'b1;

	act_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (touch.valid),
		.in_ready  (touch.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	act_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.client_key     (touch.client_key),
		.now_time       (touch.now_time),
		.cfg_wr         (cfg.valid),
		.cfg_data       (cfg.data),
		.active_clients (result.active_clients)
	);

endmodule

FILE: rtl/act_ram.sv
// ----------------------------------------------------------------------------
// act_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module act_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/act_ctrl.sv
// ----------------------------------------------------------------------------
// act_ctrl
// Sequencer: accept a touch, scan the used entries, write back, hand over
// the count.
// ----------------------------------------------------------------------------
module act_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  act_pkg::act_sts_t  sts,
	output act_pkg::act_cmd_t  cmd
);
	import act_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINAL,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   eval_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.eval     = eval_q;
		case (state_q)
			ST_IDLE:  cmd.start    = in_valid;
			ST_SCAN:  cmd.rd_en    = 1'b1;
			ST_FINAL: cmd.final_wr = 1'b1;
			ST_HOLD:  cmd.load_out = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eval_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			eval_q <= (state_q == ST_SCAN);
			// a new count replaces the one taken on this edge
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= sts.used_zero ? ST_FINAL : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.last_rd) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINAL;
				ST_FINAL: state_q <= ST_HOLD;
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/act_dp.sv
// ----------------------------------------------------------------------------
// act_dp
// Datapath: key/seen tables, window register, match and age compare,
// active count, reuse slot and fill count.
// ----------------------------------------------------------------------------
module act_dp #(
	parameter int TABLE_ENTRIES = act_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  act_pkg::act_cmd_t            cmd,
	output act_pkg::act_sts_t            sts,
	input  logic [act_pkg::KEY_W-1:0]    client_key,
	input  logic [act_pkg::TIME_W-1:0]   now_time,
	input  logic                         cfg_wr,
	input  logic [act_pkg::TIME_W-1:0]   cfg_data,
	output logic [act_pkg::OUT_W-1:0]    active_clients
);
	import act_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int UW    = $clog2(TABLE_ENTRIES + 1);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 2);
	localparam int SAT_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;

	logic [TIME_W-1:0] window_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  eidx_s1;
	logic [CNT_W-1:0]  active_q;
	logic [IDX_W-1:0]  slot_q;
	logic              have_slot_q;
	logic              found_q;
	logic [UW-1:0]     used_q;
	logic [OUT_W-1:0]  res_q;

	logic [KEY_W-1:0]  rd_key;
	logic [TIME_W-1:0] rd_seen;
	logic              match;
	logic [TIME_W-1:0] seen_eff;
	logic              entry_active;
	logic              has_room;
	logic              fin_wr;
	logic [IDX_W-1:0]  fin_addr;
	logic              seen_wr;
	logic [IDX_W-1:0]  seen_addr;
	logic [SAT_W-1:0]  act_wide;

	// a refreshed entry ages from now, so only a zero window fails it
	assign match        = (rd_key == key_q);
	assign seen_eff     = match ? now_q : rd_seen;
	assign entry_active = ((now_q - seen_eff) < window_q);

	assign has_room = (used_q < UW'(TABLE_ENTRIES));
	assign fin_wr   = cmd.final_wr && !found_q && (have_slot_q || has_room);
	assign fin_addr = have_slot_q ? slot_q : used_q[IDX_W-1:0];

	assign seen_wr   = fin_wr || (cmd.eval && match);
	assign seen_addr = cmd.final_wr ? fin_addr : eidx_s1;

	assign sts.used_zero = (used_q == '0);
	assign sts.last_rd   = ((UW'(rd_idx_q) + UW'(1)) == used_q);

	assign act_wide       = SAT_W'(active_q);
	assign active_clients = res_q;

	act_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk     (clk),
		.wr_en   (fin_wr),
		.wr_addr (fin_addr),
		.wr_data (key_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_key)
	);

	act_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_seen_ram (
		.clk     (clk),
		.wr_en   (seen_wr),
		.wr_addr (seen_addr),
		.wr_data (now_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_seen)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			used_q   <= '0;
		end else begin
			if (cfg_wr) begin
				window_q <= cfg_data;
			end
			if (fin_wr && !have_slot_q) begin
				used_q <= used_q + UW'(1);
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q       <= client_key;
			now_q       <= now_time;
			rd_idx_q    <= '0;
			active_q    <= '0;
			have_slot_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				eidx_s1  <= rd_idx_q;
			end
			if (cmd.eval) begin
				if (match) begin
					found_q <= 1'b1;
				end
				if (entry_active) begin
					active_q <= active_q + CNT_W'(1);
				end else if (!have_slot_q) begin
					slot_q      <= eidx_s1;
					have_slot_q <= 1'b1;
				end
			end
			if (cmd.final_wr && !found_q) begin
				active_q <= active_q + CNT_W'(1);
			end
		end
		if (cmd.load_out) begin
			res_q <= (act_wide > SAT_W'(OUT_MAX)) ? OUT_MAX : act_wide[OUT_W-1:0];
		end
	end

endmodule
